### hdl/true_peak_meter_4x_core_assert.svh
// Assertion macros for the true-peak meter core.
// Used by the top level only; needs nothing else.
`ifndef TRUE_PEAK_METER_4X_CORE_ASSERT_SVH
`define TRUE_PEAK_METER_4X_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TPM_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TPM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TPM_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg)

`define TPM_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

### hdl/tpm_pkg.sv
// Package for the true-peak meter: word types, fixed widths and the
// elaboration-time functions that build the interpolation kernel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpm_pkg;

  // Fixed widths of the audio words.
  localparam int SAMPLE_BITS = 24;
  localparam int PEAK_BITS   = SAMPLE_BITS + 1;
  localparam logic [PEAK_BITS-1:0] PEAK_MAX = '1;

  typedef longint unsigned u64_t;

  // Fixed-point constants for the kernel generator (Q30).
  localparam u64_t PI_Q30     = 64'd3373259426;
  localparam u64_t INV_PI_Q30 = 64'd341782638;
  localparam u64_t ONE_Q30    = 64'd1 << 30;
  localparam int   TAYLOR_TERMS = 7;

  // Input word.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
  } tpm_in_t;

  // Result word.
  typedef struct packed {
    logic [PEAK_BITS-1:0]   true_peak;
    logic [SAMPLE_BITS-1:0] sample_peak;
    logic [PEAK_BITS-1:0]   item_peak;
    logic                   window_full;
  } tpm_out_t;

  // Control that travels with each tap read.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tap_ctl_t;

  // One finished phase: rounded, saturated magnitude.
  typedef struct packed {
    logic                 vld;
    logic [PEAK_BITS-1:0] mag;
  } phase_res_t;

  // Restoring long division, used only while the kernel is elaborated.
  function automatic u64_t udiv(input u64_t num, input u64_t den);
    u64_t quo;
    u64_t rem;
    int   b;
    quo = '0;
    rem = '0;
    if (den == 0) return '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // |sin(pi*num/den)| in Q30 from a Taylor series on the folded angle.
  function automatic u64_t sin_pi_q30(input u64_t num, input u64_t den);
    u64_t   n_f;
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    longint acc;
    int     n;
    if (den == 0) return '0;
    n_f = num;
    if (n_f > den) n_f = den;
    if ((n_f << 1) > den) n_f = den - n_f;
    x    = udiv(PI_Q30 * n_f, den);
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (n = 1; n <= TAYLOR_TERMS; n++) begin
      term = udiv((term * x2) >> 30, u64_t'((2 * n) * (2 * n + 1)));
      if (n[0]) acc = acc - longint'(term);
      else      acc = acc + longint'(term);
    end
    return (acc < 0) ? '0 : u64_t'(acc);
  endfunction

  // Windowed sinc tap before normalisation, signed Q30.
  function automatic longint kernel_raw(input int idx, input int os, input int half);
    int   k;
    u64_t a;
    u64_t sinc;
    u64_t s;
    u64_t w;
    u64_t v;
    u64_t os_u;
    u64_t span;
    u64_t grp;
    logic neg;
    os_u = u64_t'(os);
    span = u64_t'(2 * half * os);
    k    = idx - half * os;
    a    = (k < 0) ? u64_t'(-k) : u64_t'(k);
    neg  = 1'b0;
    if (a == 0) begin
      sinc = ONE_Q30;
    end else begin
      grp  = udiv(a, os_u);
      s    = sin_pi_q30(a - grp * os_u, os_u);
      sinc = udiv(((s * os_u) * INV_PI_Q30) >> 30, a);
      neg  = grp[0];
    end
    s = sin_pi_q30(u64_t'(idx), span);
    w = (s * s) >> 30;
    v = (sinc * w) >> 30;
    return neg ? -longint'(v) : longint'(v);
  endfunction

  // Sum of all raw taps, never below one.
  function automatic longint kernel_total(input int os, input int half);
    longint total;
    int     i;
    total = 0;
    for (i = 0; i <= 2 * half * os; i++) begin
      total = total + kernel_raw(i, os, half);
    end
    if (total <= 0) total = 1;
    return total;
  endfunction

  // Normalised tap: magnitude rounded half up, then given the tap's sign.
  function automatic longint kernel_coef(input int idx, input int os, input int half,
                                         input int cfrac, input longint total);
    longint raw;
    u64_t   mag;
    u64_t   c;
    u64_t   tot_u;
    raw   = kernel_raw(idx, os, half);
    mag   = (raw < 0) ? u64_t'(-raw) : u64_t'(raw);
    tot_u = u64_t'(total);
    c     = udiv(((mag * u64_t'(os)) << cfrac) + (tot_u >> 1), tot_u);
    return (raw < 0) ? -longint'(c) : longint'(c);
  endfunction

endpackage

`default_nettype wire

### hdl/tpm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tpm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 25,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/tpm_mac.sv
// Polyphase multiply-accumulate unit: coefficient ROM, one shared multiplier,
// accumulator and rounding to a saturated magnitude. Depends on tpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpm_mac #(
  parameter int OVERSAMPLE = 4,
  parameter int HALF_LEN   = 12,
  parameter int COEF_BITS  = 18,
  localparam int KER_LEN = 2 * HALF_LEN * OVERSAMPLE + 1,
  localparam int KI_W    = $clog2(KER_LEN)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tpm_pkg::tap_ctl_t                      tap_ctl,
  input  logic [KI_W-1:0]                        coef_idx,
  input  logic signed [tpm_pkg::SAMPLE_BITS-1:0] sample,
  output tpm_pkg::phase_res_t                    phase_res
);

  localparam int LINE_LEN = 2 * HALF_LEN + 1;
  localparam int CFRAC    = COEF_BITS - 2;
  localparam int PROD_W   = tpm_pkg::SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W    = PROD_W + $clog2(LINE_LEN + 1);
  localparam logic [ACC_W:0] HALF_LSB = {{ACC_W{1'b0}}, 1'b1} << (CFRAC - 1);
  localparam logic [ACC_W:0] PEAK_LIM =
    {{(ACC_W + 1 - tpm_pkg::PEAK_BITS){1'b0}}, tpm_pkg::PEAK_MAX};
  localparam longint KER_TOTAL = tpm_pkg::kernel_total(OVERSAMPLE, HALF_LEN);

  // Coefficient table, built at elaboration.
  logic signed [COEF_BITS-1:0] coef_rom [KER_LEN];

  for (genvar g = 0; g < KER_LEN; g++) begin : g_coef
    localparam longint CoefVal =
      tpm_pkg::kernel_coef(g, OVERSAMPLE, HALF_LEN, CFRAC, KER_TOTAL);
    assign coef_rom[g] = COEF_BITS'(CoefVal);
  end

  tpm_pkg::tap_ctl_t           ctl1_r, ctl1_nxt;
  logic signed [COEF_BITS-1:0] coef1_r, coef1_nxt;
  tpm_pkg::tap_ctl_t           ctl2_r, ctl2_nxt;
  logic signed [PROD_W-1:0]    prod2_r, prod2_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic                        done3_r, done3_nxt;
  tpm_pkg::phase_res_t         res4_r, res4_nxt;

  logic [ACC_W-1:0] acc_mag;
  logic [ACC_W:0]   rnd;

  // Stage 1: the coefficient lines up with the sample read from the RAM.
  always_comb begin
    ctl1_nxt  = tap_ctl;
    coef1_nxt = coef_rom[coef_idx];
  end

  // Stage 2: one signed product.
  always_comb begin
    ctl2_nxt  = ctl1_r;
    prod2_nxt = PROD_W'(sample) * PROD_W'(coef1_r);
  end

  // Stage 3: accumulate; the first tap of a phase restarts the sum.
  always_comb begin
    acc_nxt   = acc_r;
    done3_nxt = 1'b0;
    if (ctl2_r.vld) begin
      acc_nxt   = (ctl2_r.first ? '0 : acc_r) + ACC_W'(prod2_r);
      done3_nxt = ctl2_r.last;
    end
  end

  // Stage 4: magnitude, round half up dropping CFRAC fraction bits, saturate.
  always_comb begin
    acc_mag = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    rnd     = ({1'b0, acc_mag} + HALF_LSB) >> CFRAC;
    res4_nxt.vld = done3_r;
    res4_nxt.mag = (rnd > PEAK_LIM) ? tpm_pkg::PEAK_MAX : rnd[tpm_pkg::PEAK_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r     <= '0;
      ctl2_r     <= '0;
      done3_r    <= 1'b0;
      res4_r.vld <= 1'b0;
    end else begin
      ctl1_r     <= ctl1_nxt;
      ctl2_r     <= ctl2_nxt;
      done3_r    <= done3_nxt;
      res4_r.vld <= res4_nxt.vld;
    end
    coef1_r    <= coef1_nxt;
    prod2_r    <= prod2_nxt;
    acc_r      <= acc_nxt;
    res4_r.mag <= res4_nxt.mag;
  end

  assign phase_res = res4_r;

endmodule

`default_nettype wire

### hdl/true_peak_meter_4x_core.sv
// True-peak meter with polyphase oversampling, top level.
// Depends on tpm_pkg, tpm_ram, tpm_mac and true_peak_meter_4x_core_assert.svh.
//
// Usage: one audio word enters on in_valid/in_ready (sample, restart) and one
// result word leaves on out_valid/out_ready (true_peak, sample_peak,
// item_peak, window_full). Every input word gives exactly one result word.
// The sample history sits in a circular RAM of 2*HALF_LEN+1 entries; each
// input word is written to it and, once the line is full, the shared MAC
// reads it back 2*HALF_LEN*OVERSAMPLE+1 times, one tap per cycle, to form
// all OVERSAMPLE phases.
// During warm-up a word goes straight to its result; with a full line the
// core runs every tap, one per cycle through the RAM read port, and then
// drains the four-stage MAC pipeline before the result is loaded.
// The result is registered; in_ready rises again once it is loaded, so a
// new word is taken while the last result still waits.
// If the receiver stalls with a result pending, the next result waits in
// the core and in_ready stays low until the output register is free.
// Reset empties the measurement: fill count and both peaks are zero. The
// RAM needs no clearing, as entries are read only after they are written.
`timescale 1ns / 1ps
`default_nettype none
`include "true_peak_meter_4x_core_assert.svh"

module true_peak_meter_4x_core #(
  parameter int OVERSAMPLE = 4,
  parameter int HALF_LEN   = 12,
  parameter int COEF_BITS  = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpm_pkg::tpm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tpm_pkg::tpm_out_t out_data
);

  localparam int LINE_LEN = 2 * HALF_LEN + 1;
  localparam int AW       = $clog2(LINE_LEN);
  localparam int FILL_W   = $clog2(LINE_LEN + 1);
  localparam int PW       = $clog2(OVERSAMPLE);
  localparam int KER_LEN  = 2 * HALF_LEN * OVERSAMPLE + 1;
  localparam int KI_W     = $clog2(KER_LEN);
  localparam int SB       = tpm_pkg::SAMPLE_BITS;
  localparam int PB       = tpm_pkg::PEAK_BITS;

  localparam logic [AW-1:0]     LAST_D    = AW'(LINE_LEN - 1);
  localparam logic [PW-1:0]     LAST_P    = PW'(OVERSAMPLE - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(LINE_LEN);
  localparam logic [AW:0]       LINE_WRAP = (AW + 1)'(LINE_LEN);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [AW-1:0]     d_r, d_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic [PW-1:0]     ph_cnt_r, ph_cnt_nxt;
  logic [PB-1:0]     tp_r, tp_nxt;
  logic [SB-1:0]     sp_r, sp_nxt;
  logic [PB-1:0]     item_r, item_nxt;
  logic              full_r, full_nxt;
  logic              out_valid_r, out_valid_nxt;
  tpm_pkg::tpm_out_t out_data_r, out_data_nxt;

  logic                accept;
  logic [AW-1:0]       wp_inc;
  logic [SB-1:0]       x_mag;
  logic [SB-1:0]       sp_base;
  logic [FILL_W-1:0]   fill_inc;
  logic                win_full;
  logic [AW:0]         addr_sum;
  logic [AW-1:0]       rd_addr;
  logic [SB-1:0]       rd_data;
  logic [KI_W-1:0]     coef_idx;
  tpm_pkg::tap_ctl_t   tap_ctl;
  tpm_pkg::phase_res_t phase_res;
  logic [PB-1:0]       item_max;
  logic [PB-1:0]       tp_base;

  assign accept = in_valid && in_ready;

  // Sample history: written on acceptance, read one tap per cycle.
  tpm_ram #(
    .WIDTH(SB),
    .DEPTH(LINE_LEN)
  ) u_hist (
    .clk  (clk),
    .we   (accept),
    .waddr(wp_r),
    .wdata(in_data.sample),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Tap address: the oldest sample sits at base_r, newer ones follow.
  always_comb begin
    addr_sum = {1'b0, base_r} + {1'b0, d_r};
    rd_addr  = (addr_sum >= LINE_WRAP) ? AW'(addr_sum - LINE_WRAP) : addr_sum[AW-1:0];
    coef_idx = KI_W'(d_r) * KI_W'(OVERSAMPLE) - KI_W'(p_r);
    tap_ctl.vld   = (state_r == ST_MAC);
    tap_ctl.first = (p_r == '0) ? (d_r == '0) : (d_r == AW'(1));
    tap_ctl.last  = (d_r == LAST_D);
  end

  tpm_mac #(
    .OVERSAMPLE(OVERSAMPLE),
    .HALF_LEN  (HALF_LEN),
    .COEF_BITS (COEF_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .tap_ctl  (tap_ctl),
    .coef_idx (coef_idx),
    .sample   (rd_data),
    .phase_res(phase_res)
  );

  // Helpers for the word being accepted and the phase being finished.
  always_comb begin
    wp_inc   = (wp_r == LAST_D) ? '0 : wp_r + AW'(1);
    x_mag    = in_data.sample[SB-1] ? SB'(-in_data.sample) : SB'(in_data.sample);
    sp_base  = in_data.restart ? '0 : sp_r;
    fill_inc = in_data.restart ? FILL_W'(1) :
               ((fill_r == FILL_FULL) ? fill_r : fill_r + FILL_W'(1));
    win_full = (fill_inc == FILL_FULL);
    item_max = (phase_res.mag > item_r) ? phase_res.mag : item_r;
    tp_base  = in_data.restart ? '0 : tp_r;
  end

  // Sequencer and measurement state.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    base_nxt      = base_r;
    d_nxt         = d_r;
    p_nxt         = p_r;
    ph_cnt_nxt    = ph_cnt_r;
    tp_nxt        = tp_r;
    sp_nxt        = sp_r;
    item_nxt      = item_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fill_nxt   = fill_inc;
          wp_nxt     = wp_inc;
          base_nxt   = wp_inc;
          d_nxt      = '0;
          p_nxt      = '0;
          ph_cnt_nxt = '0;
          tp_nxt     = tp_base;
          sp_nxt     = (x_mag > sp_base) ? x_mag : sp_base;
          item_nxt   = '0;
          full_nxt   = win_full;
          state_nxt  = win_full ? ST_MAC : ST_DONE;
        end
      end
      ST_MAC: begin
        // One tap per cycle; each phase after the first skips the oldest sample.
        if (d_r == LAST_D) begin
          if (p_r == LAST_P) begin
            state_nxt = ST_DRAIN;
          end else begin
            p_nxt = p_r + PW'(1);
            d_nxt = AW'(1);
          end
        end else begin
          d_nxt = d_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DRAIN;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.true_peak   = tp_r;
          out_data_nxt.sample_peak = sp_r;
          out_data_nxt.item_peak   = item_r;
          out_data_nxt.window_full = full_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Finished phases update the item peak; the last one closes the word.
    if (phase_res.vld) begin
      item_nxt   = item_max;
      ph_cnt_nxt = ph_cnt_r + PW'(1);
      if (ph_cnt_r == LAST_P) begin
        tp_nxt    = (item_max > tp_r) ? item_max : tp_r;
        state_nxt = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      wp_r        <= '0;
      tp_r        <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      tp_r        <= tp_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    base_r     <= base_nxt;
    d_r        <= d_nxt;
    p_r        <= p_nxt;
    ph_cnt_r   <= ph_cnt_nxt;
    item_r     <= item_nxt;
    full_r     <= full_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer and the result word.
  `TPM_ASSERT_IMPLIES(a_phase_in_compute, clk, rst_n, phase_res.vld, (state_r == ST_MAC) || (state_r == ST_DRAIN), "phase result outside the compute states")
  `TPM_ASSERT_IMPLIES(a_peak_order, clk, rst_n, out_valid && out_data.window_full, out_data.true_peak >= out_data.item_peak, "item peak above the running true peak")
  `TPM_ASSERT_IMPLIES(a_warmup_zero, clk, rst_n, out_valid && !out_data.window_full, out_data.item_peak == '0, "item peak set during warm-up")
  `TPM_ASSERT_NEXT(a_fill_after_accept, clk, rst_n, in_valid && in_ready, fill_r != '0, "fill count empty after an accepted word")

endmodule

`default_nettype wire

### tb/sv/true_peak_meter_4x_core_tb.sv
// Self-checking testbench for the true-peak meter core: directed and random
// audio words, checked against a fixed-point predictor of the oversampled peak.
// Depends on tpm_pkg and true_peak_meter_4x_core.
`timescale 1ns / 1ps

module true_peak_meter_4x_core_tb;

  // Geometry of the default core.
  localparam int OS        = 4;
  localparam int HL        = 12;
  localparam int LINE_LEN  = 2 * HL + 1;
  localparam int KER_HALF  = HL * OS;
  localparam int KER_LEN   = 2 * KER_HALF + 1;
  localparam int CFRAC     = 16;

  // Fixed-point constants of the kernel, Q30.
  localparam longint unsigned PI_FX     = 64'd3373259426;
  localparam longint unsigned INV_PI_FX = 64'd341782638;
  localparam longint unsigned UNIT_FX   = 64'd1 << 30;

  localparam int MAX_POS = 8388607;
  localparam int MAX_NEG = -8388608;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 256;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  tpm_pkg::tpm_in_t   in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tpm_pkg::tpm_out_t  out_data;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int error_count = 0;
  int stall_cycles = 0;

  // Predictor state: interpolation kernel, sample line and running peaks.
  longint                                 kernel_tap [KER_LEN];
  logic signed [tpm_pkg::SAMPLE_BITS-1:0] line_samples [LINE_LEN];
  logic [4:0]                             line_fill;
  logic [tpm_pkg::PEAK_BITS-1:0]          peak_interp;
  logic [tpm_pkg::SAMPLE_BITS-1:0]        peak_input;
  tpm_pkg::tpm_out_t                      peak_words_due [$];

  true_peak_meter_4x_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // |sin(pi*num/den)| in Q30, Taylor series on the angle folded to [0, pi/2].
  function automatic longint unsigned sine_fx(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    int              n;
    if (den == 0) return 0;
    if (num > den) num = den;
    if (2 * num > den) num = den - num;
    x    = PI_FX * num / den;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    return (sum < 0) ? 0 : longint'(sum);
  endfunction

  // Hann-windowed sinc, normalised so the taps sum to the oversampling factor.
  task automatic build_kernel_taps();
    longint          raw [KER_LEN];
    longint          total;
    longint unsigned a, sinc, s, w, v, mag, c;
    int              i, k;
    logic            neg;
    total = 0;
    for (i = 0; i < KER_LEN; i++) begin
      k   = i - KER_HALF;
      a   = (k < 0) ? longint'(-k) : longint'(k);
      neg = 1'b0;
      if (a == 0) begin
        sinc = UNIT_FX;
      end else begin
        s    = sine_fx(a % OS, OS);
        sinc = (((s * OS) * INV_PI_FX) >> 30) / a;
        neg  = ((a / OS) % 2) == 1;
      end
      s      = sine_fx(longint'(i), KER_LEN - 1);
      w      = (s * s) >> 30;
      v      = (sinc * w) >> 30;
      raw[i] = neg ? -longint'(v) : longint'(v);
      total  = total + raw[i];
    end
    if (total <= 0) total = 1;
    for (i = 0; i < KER_LEN; i++) begin
      mag = (raw[i] < 0) ? longint'(-raw[i]) : longint'(raw[i]);
      c   = (mag * OS) << CFRAC;
      c   = (c + longint'(total) / 2) / longint'(total);
      kernel_tap[i] = (raw[i] < 0) ? -longint'(c) : longint'(c);
    end
  endtask

  task automatic clear_meter();
    int d;
    for (d = 0; d < LINE_LEN; d++) line_samples[d] = '0;
    line_fill   = '0;
    peak_interp = '0;
    peak_input  = '0;
  endtask

  // Advances the predicted meter by one word and queues the result it must give.
  task automatic predict_peaks(input tpm_pkg::tpm_in_t w);
    longint                        x, acc;
    longint unsigned               mag, r;
    logic [tpm_pkg::PEAK_BITS-1:0] item;
    logic                          full;
    tpm_pkg::tpm_out_t             res;
    int                            p, d;
    x    = longint'(w.sample);
    item = '0;
    if (w.restart) clear_meter();
    for (d = 0; d < LINE_LEN - 1; d++) line_samples[d] = line_samples[d + 1];
    line_samples[LINE_LEN - 1] = w.sample;
    if (line_fill < LINE_LEN) line_fill = line_fill + 1'b1;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    if (mag > peak_input) peak_input = mag[tpm_pkg::SAMPLE_BITS-1:0];
    full = (line_fill >= LINE_LEN);
    if (full) begin
      // Every phase of the instant half a line back; keep the largest magnitude.
      for (p = 0; p < OS; p++) begin
        acc = 0;
        for (d = (p != 0) ? 1 : 0; d < LINE_LEN; d++) begin
          acc = acc + longint'(line_samples[d]) * kernel_tap[OS * d - p];
        end
        r = (acc < 0) ? longint'(-acc) : longint'(acc);
        r = (r + (64'd1 << (CFRAC - 1))) >> CFRAC;
        if (r > tpm_pkg::PEAK_MAX) r = tpm_pkg::PEAK_MAX;
        if (r > item) item = r[tpm_pkg::PEAK_BITS-1:0];
      end
      if (item > peak_interp) peak_interp = item;
    end
    res.true_peak   = peak_interp;
    res.sample_peak = peak_input;
    res.item_peak   = item;
    res.window_full = full;
    peak_words_due.push_back(res);
  endtask

  // Offers one word at the falling edge, with random idle cycles first.
  task automatic send_word(input int value, input logic restart);
    tpm_pkg::tpm_in_t w;
    w.sample  = value[tpm_pkg::SAMPLE_BITS-1:0];
    w.restart = restart;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_peaks(w);
  endtask

  task automatic report_field(input string fname, input longint unsigned want,
                              input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      error_count++;
    end
  endtask

  // Receiver stalls are drawn afresh each cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Each result word is matched against the oldest prediction.
  always @(posedge clk) begin
    tpm_pkg::tpm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (peak_words_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = peak_words_due.pop_front();
        report_field("true_peak", want.true_peak, out_data.true_peak);
        report_field("sample_peak", want.sample_peak, out_data.sample_peak);
        report_field("item_peak", want.item_peak, out_data.item_peak);
        report_field("window_full", want.window_full, out_data.window_full);
      end
    end
  end

  // Ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Full-scale samples whose signs follow the half-way phase of the kernel give
  // the largest overshoot; the line also starts from a restart and warms up.
  task automatic test_full_scale_overshoot();
    int d;
    send_word(0, 1'b1);
    for (d = 1; d < LINE_LEN; d++) begin
      send_word((kernel_tap[OS * d - 2] >= 0) ? MAX_POS : MAX_NEG, 1'b0);
    end
    send_word(MAX_NEG, 1'b0);
    send_word(MAX_POS, 1'b0);
  endtask

  // A restart with a full line empties history and both peaks.
  task automatic test_restart_mid_run();
    send_word(5, 1'b1);
    send_word(-1, 1'b0);
    send_word(0, 1'b0);
  endtask

  function automatic int random_sample(input int style);
    int v;
    case (style)
      0: begin
        v = $urandom;
        v = $signed(v[tpm_pkg::SAMPLE_BITS-1:0]);
      end
      1: v = $urandom_range(1) ? MAX_POS : MAX_NEG;
      2: v = int'($urandom_range(511)) - 256;
      default: begin
        v = MAX_POS - int'($urandom_range(4095));
        if ($urandom_range(1)) v = -v - 1;
      end
    endcase
    return v;
  endfunction

  // Mostly runs long enough to fill the line, some cut short by a restart.
  task automatic test_random_streams(input int n_words, input int src_pct,
                                     input int sink_pct);
    int sent, seg_len, style, i;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_words) begin
      seg_len = ($urandom_range(99) < 15) ? $urandom_range(1, LINE_LEN - 1)
                                          : $urandom_range(LINE_LEN + 1, 90);
      style   = $urandom_range(3);
      for (i = 0; i < seg_len && sent < n_words; i++) begin
        send_word(random_sample(style), (i == 0) && (sent != 0 || $urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    build_kernel_taps();
    clear_meter();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_full_scale_overshoot();
    test_restart_mid_run();
    test_random_streams(200, 0, 0);
    test_random_streams(180, 85, 0);
    test_random_streams(180, 0, 85);
    test_random_streams(190, 22, 22);

    // Drain the last results, then let the core settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (peak_words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
